// ===== rtl/pnq_pkg.sv =====
// Shared types and constants for the pitch note quantizer.
package pnq_pkg;

   localparam int PITCH_W       = 18;
   localparam int MARGIN_W      = 11;
   localparam int SEMI_W        = 4;
   localparam int OCT_W         = 4;
   localparam int BAND_W        = 2;
   localparam int DEV_W         = 12;
   localparam int SEMIS_PER_OCT = 12;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] REG_MARGIN   = 1'b0;
   localparam logic [MARGIN_W-1:0]    MARGIN_RESET = 11'd320;

   typedef enum logic {
      FUNC_SAMPLE = 1'b0,
      FUNC_CLEAR  = 1'b1
   } func_type;

   typedef enum logic [BAND_W-1:0] {
      BAND_LOWER  = 2'd0,
      BAND_MIDDLE = 2'd1,
      BAND_UPPER  = 2'd2,
      BAND_OTHER  = 2'd3
   } band_type;

   typedef struct packed {
      logic valid;
      logic clear;
   } stage_ctl_type;

endpackage

// ===== rtl/pnq_csr.sv =====
// Register port holding the hysteresis margin.
module pnq_csr import pnq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [MARGIN_W-1:0]   margin
);

   logic [MARGIN_W-1:0]    margin_ff;
   logic [CSR_INDEX_W-1:0] index;
   logic                   write_en;

   assign index      = csr_paddr[CSR_ADDR_W-1 -: CSR_INDEX_W];
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign margin     = margin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_RESET;
      end else if (write_en && (index == REG_MARGIN)) begin
         margin_ff <= csr_pwdata[MARGIN_W-1:0];
      end
   end

   always_comb begin
      unique case (index)
         REG_MARGIN: begin
            csr_prdata = {{(CSR_DATA_W-MARGIN_W){1'b0}}, margin_ff};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

endmodule

// ===== rtl/pnq_round.sv =====
// Input register, pitch saturation and nearest-semitone rounding stage.
module pnq_round import pnq_pkg::*; #(
   parameter int FRAC_BITS   = 4,
   parameter int MAX_OCTAVES = 4,
   localparam int UNITS_SEMI = 100 * (2 ** FRAC_BITS),
   localparam int HALF_SEMI  = 50 * (2 ** FRAC_BITS),
   localparam int LIMIT      = MAX_OCTAVES * 1200 * (2 ** FRAC_BITS),
   localparam int PITCH_SPAN = 2 ** (PITCH_W - 1),
   localparam int MAG_MAX    = (LIMIT < PITCH_SPAN) ? LIMIT : PITCH_SPAN,
   localparam int XW         = $clog2(MAG_MAX + HALF_SEMI + 1),
   localparam int QMAX       = (MAG_MAX + HALF_SEMI) / UNITS_SEMI,
   localparam int QW         = $clog2(QMAX + 1),
   localparam int CW         = QW + 1,
   localparam int UW         = XW + 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_func,
   input  logic signed [PITCH_W-1:0]  req_pitch_cents,
   output stage_ctl_type              mid_ctl,
   output logic signed [UW-1:0]       mid_pitch,
   output logic signed [CW-1:0]       mid_center,
   input  logic                       mid_ready
);

   localparam int SW_A = $clog2(LIMIT + 1) + 3;
   localparam int SW   = (SW_A > PITCH_W + 2) ? SW_A : PITCH_W + 2;
   localparam int SH   = XW + $clog2(UNITS_SEMI);
   localparam int MW   = XW + 1;
   localparam int PW   = XW + MW;
   localparam logic [63:0] MULT_WIDE =
      ((64'd1 << SH) + 64'(UNITS_SEMI) - 64'd1) / 64'(UNITS_SEMI);
   localparam logic [MW-1:0]        MULT   = MULT_WIDE[MW-1:0];
   localparam logic signed [SW-1:0] SAT_HI = SW'(LIMIT - 1);
   localparam logic signed [SW-1:0] SAT_LO = SW'(-LIMIT);
   localparam logic [SW-1:0]        HALF_S = SW'(HALF_SEMI);

   logic                      in_valid_ff, in_valid_in;
   logic                      in_func_ff;
   logic signed [PITCH_W-1:0] in_pitch_ff;

   logic                      mid_valid_ff, mid_valid_in;
   logic                      mid_clear_ff;
   logic signed [UW-1:0]      mid_pitch_ff, mid_pitch_in;
   logic signed [CW-1:0]      mid_center_ff, mid_center_in;

   logic                      load_mid;
   logic                      neg;
   logic signed [SW-1:0]      pitch_ext, pitch_sat;
   logic [SW-1:0]             mag, mag_half;
   logic [XW-1:0]             x;
   logic [PW-1:0]             prod;
   logic [QW-1:0]             q;
   logic [CW-1:0]             q_ext;

   assign load_mid  = in_valid_ff && (!mid_valid_ff || mid_ready);
   assign req_ready = !in_valid_ff || load_mid;

   always_comb begin
      in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !load_mid);
      mid_valid_in = load_mid || (mid_valid_ff && !mid_ready);
   end

   always_comb begin
      pitch_ext = {{(SW-PITCH_W){in_pitch_ff[PITCH_W-1]}}, in_pitch_ff};
      priority if (pitch_ext < SAT_LO) begin
         pitch_sat = SAT_LO;
      end else if (pitch_ext > SAT_HI) begin
         pitch_sat = SAT_HI;
      end else begin
         pitch_sat = pitch_ext;
      end
      neg      = pitch_sat[SW-1];
      mag      = neg ? -pitch_sat : pitch_sat;
      mag_half = mag + HALF_S;
      x        = mag_half[XW-1:0];
      prod     = PW'(x) * PW'(MULT);
      q        = prod[SH +: QW];
      q_ext    = {1'b0, q};
      mid_center_in = neg ? -q_ext : q_ext;
      mid_pitch_in  = pitch_sat[UW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mid_valid_ff <= mid_valid_in;
      end
      if (req_valid && req_ready) begin
         in_func_ff  <= req_func;
         in_pitch_ff <= req_pitch_cents;
      end
      if (load_mid) begin
         mid_clear_ff  <= (in_func_ff == FUNC_CLEAR);
         mid_pitch_ff  <= mid_pitch_in;
         mid_center_ff <= mid_center_in;
      end
   end

   assign mid_ctl.valid = mid_valid_ff;
   assign mid_ctl.clear = mid_clear_ff;
   assign mid_pitch     = mid_pitch_ff;
   assign mid_center    = mid_center_ff;

endmodule

// ===== rtl/pnq_lock.sv =====
// Lock state, hysteresis decision and result register.
module pnq_lock import pnq_pkg::*; #(
   parameter int FRAC_BITS   = 4,
   parameter int MAX_OCTAVES = 4,
   localparam int UNITS_SEMI = 100 * (2 ** FRAC_BITS),
   localparam int HALF_SEMI  = 50 * (2 ** FRAC_BITS),
   localparam int LIMIT      = MAX_OCTAVES * 1200 * (2 ** FRAC_BITS),
   localparam int PITCH_SPAN = 2 ** (PITCH_W - 1),
   localparam int MAG_MAX    = (LIMIT < PITCH_SPAN) ? LIMIT : PITCH_SPAN,
   localparam int XW         = $clog2(MAG_MAX + HALF_SEMI + 1),
   localparam int QMAX       = (MAG_MAX + HALF_SEMI) / UNITS_SEMI,
   localparam int QW         = $clog2(QMAX + 1),
   localparam int CW         = QW + 1,
   localparam int UW         = XW + 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [MARGIN_W-1:0]       margin,
   input  stage_ctl_type             mid_ctl,
   input  logic signed [UW-1:0]      mid_pitch,
   input  logic signed [CW-1:0]      mid_center,
   output logic                      mid_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [SEMI_W-1:0]         rsp_semitone,
   output logic signed [OCT_W-1:0]   rsp_octave,
   output logic [BAND_W-1:0]         rsp_band,
   output logic signed [DEV_W-1:0]   rsp_deviation
);

   localparam int DW   = UW + 1;
   localparam int OQW  = CW - 3;
   localparam int S12  = CW + 4;
   localparam int M12W = CW + 1;
   localparam int P12W = CW + M12W;
   localparam logic [63:0] M12_WIDE =
      ((64'd1 << S12) + 64'(SEMIS_PER_OCT) - 64'd1) / 64'(SEMIS_PER_OCT);
   localparam logic [M12W-1:0]      M12     = M12_WIDE[M12W-1:0];
   localparam logic signed [UW-1:0] SEMI_S  = UW'(UNITS_SEMI);
   localparam logic signed [CW-1:0] OCT_M1  = CW'(-1);
   localparam logic signed [CW-1:0] OCT_0   = CW'(0);
   localparam logic signed [CW-1:0] OCT_P1  = CW'(1);

   logic                      lock_ff;
   logic signed [UW-1:0]      units_ff;
   logic signed [CW-1:0]      oct_ff;
   logic [SEMI_W-1:0]         semi_ff;

   logic                      out_valid_ff, out_valid_in;
   logic [SEMI_W-1:0]         out_semi_ff;
   logic signed [OCT_W-1:0]   out_oct_ff;
   logic [BAND_W-1:0]         out_band_ff;
   logic signed [DEV_W-1:0]   out_dev_ff;

   logic                      fire;
   logic signed [DW-1:0]      diff;
   logic [DW-1:0]             abs_diff;
   logic [DW:0]               twice_diff, thresh;
   logic                      relock;
   logic signed [UW-1:0]      center_ext, cand_units;
   logic                      cand_neg;
   logic [CW-1:0]             cand_mag, y;
   logic [P12W-1:0]           prod12;
   logic [OQW-1:0]            oq;
   logic [CW-1:0]             oq_ext;
   logic signed [CW-1:0]      cand_oct;
   logic signed [CW+1:0]      oct_wide, oct_x12, center_wide, semi_wide;
   logic [SEMI_W-1:0]         cand_semi;
   logic signed [UW-1:0]      units_new;
   logic signed [CW-1:0]      oct_new;
   logic [SEMI_W-1:0]         semi_new;
   logic signed [DW-1:0]      dev_full;
   band_type                  band_new;

   assign mid_ready = !out_valid_ff || rsp_ready;
   assign fire      = mid_ctl.valid && mid_ready;

   always_comb begin
      out_valid_in = (fire && !mid_ctl.clear) || (out_valid_ff && !rsp_ready);
   end

   always_comb begin
      diff       = {mid_pitch[UW-1], mid_pitch} - {units_ff[UW-1], units_ff};
      abs_diff   = diff[DW-1] ? -diff : diff;
      twice_diff = {abs_diff, 1'b0};
      thresh     = (DW+1)'(UNITS_SEMI) + (DW+1)'(margin);
      relock     = !lock_ff || (twice_diff > thresh);

      center_ext = {{(UW-CW){mid_center[CW-1]}}, mid_center};
      cand_units = center_ext * SEMI_S;

      // floored division of the candidate center by twelve
      cand_neg = mid_center[CW-1];
      cand_mag = cand_neg ? -mid_center : mid_center;
      y        = cand_mag + (cand_neg ? CW'(SEMIS_PER_OCT - 1) : CW'(0));
      prod12   = P12W'(y) * P12W'(M12);
      oq       = prod12[S12 +: OQW];
      oq_ext   = {{(CW-OQW){1'b0}}, oq};
      cand_oct = cand_neg ? -oq_ext : oq_ext;

      oct_wide    = {{2{cand_oct[CW-1]}}, cand_oct};
      oct_x12     = (oct_wide <<< 3) + (oct_wide <<< 2);
      center_wide = {{2{mid_center[CW-1]}}, mid_center};
      semi_wide   = center_wide - oct_x12;
      cand_semi   = semi_wide[SEMI_W-1:0];

      units_new = relock ? cand_units : units_ff;
      oct_new   = relock ? cand_oct   : oct_ff;
      semi_new  = relock ? cand_semi  : semi_ff;
      dev_full  = {mid_pitch[UW-1], mid_pitch} - {units_new[UW-1], units_new};

      priority if (oct_new == OCT_M1) begin
         band_new = BAND_LOWER;
      end else if (oct_new == OCT_0) begin
         band_new = BAND_MIDDLE;
      end else if (oct_new == OCT_P1) begin
         band_new = BAND_UPPER;
      end else begin
         band_new = BAND_OTHER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         lock_ff      <= 1'b0;
         units_ff     <= '0;
         oct_ff       <= '0;
         semi_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            if (mid_ctl.clear) begin
               lock_ff  <= 1'b0;
               units_ff <= '0;
               oct_ff   <= '0;
               semi_ff  <= '0;
            end else begin
               lock_ff  <= 1'b1;
               units_ff <= units_new;
               oct_ff   <= oct_new;
               semi_ff  <= semi_new;
            end
         end
      end
      if (fire && !mid_ctl.clear) begin
         out_semi_ff <= semi_new;
         out_oct_ff  <= oct_new[OCT_W-1:0];
         out_band_ff <= band_new;
         out_dev_ff  <= dev_full[DEV_W-1:0];
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_semitone  = out_semi_ff;
   assign rsp_octave    = out_oct_ff;
   assign rsp_band      = out_band_ff;
   assign rsp_deviation = out_dev_ff;

endmodule

// ===== rtl/pitch_note_quantizer_hysteresis.sv =====
// Top level of the semitone quantizer with hysteresis.
//
// Request channel (req_): one beat carries func and pitch_cents. func selects
// a pitch sample or a clear; a clear drops the lock and returns no beat.
// Result channel (rsp_): semitone, octave, band and deviation of a sample.
// Register port (csr_): hysteresis margin at byte address 0, reset 320.
//
// Throughput: one beat per cycle while rsp_ready is held high. The only loop is
// the lock state in the decision stage, which is read and written in the same cycle.
// A taken request beat passes through the input register, rounding register
// and result register, in that order, before rsp_valid rises.
// A stalled receiver holds the result register; the input and rounding
// registers still fill, so up to two more beats are taken before req_ready
// drops.
// Reset clears all valid flags and the lock, and loads the margin default.
// Margin writes must be made only while no beat is in flight; not enforced.
module pitch_note_quantizer_hysteresis import pnq_pkg::*; #(
   parameter int FRAC_BITS   = 4,
   parameter int MAX_OCTAVES = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_func,
   input  logic signed [PITCH_W-1:0] req_pitch_cents,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [SEMI_W-1:0]         rsp_semitone,
   output logic signed [OCT_W-1:0]   rsp_octave,
   output logic [BAND_W-1:0]         rsp_band,
   output logic signed [DEV_W-1:0]   rsp_deviation,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [CSR_DATA_W-1:0]     csr_pwdata,
   output logic [CSR_DATA_W-1:0]     csr_prdata,
   output logic                      csr_pready
);

   localparam int UNITS_SEMI = 100 * (2 ** FRAC_BITS);
   localparam int HALF_SEMI  = 50 * (2 ** FRAC_BITS);
   localparam int LIMIT      = MAX_OCTAVES * 1200 * (2 ** FRAC_BITS);
   localparam int PITCH_SPAN = 2 ** (PITCH_W - 1);
   localparam int MAG_MAX    = (LIMIT < PITCH_SPAN) ? LIMIT : PITCH_SPAN;
   localparam int XW         = $clog2(MAG_MAX + HALF_SEMI + 1);
   localparam int QMAX       = (MAG_MAX + HALF_SEMI) / UNITS_SEMI;
   localparam int QW         = $clog2(QMAX + 1);
   localparam int CW         = QW + 1;
   localparam int UW         = XW + 2;

   logic [MARGIN_W-1:0]   margin;
   stage_ctl_type         mid_ctl;
   logic signed [UW-1:0]  mid_pitch;
   logic signed [CW-1:0]  mid_center;
   logic                  mid_ready;

   pnq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .margin      (margin)
   );

   pnq_round #(
      .FRAC_BITS   (FRAC_BITS),
      .MAX_OCTAVES (MAX_OCTAVES)
   ) u_round (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_pitch_cents (req_pitch_cents),
      .mid_ctl         (mid_ctl),
      .mid_pitch       (mid_pitch),
      .mid_center      (mid_center),
      .mid_ready       (mid_ready)
   );

   pnq_lock #(
      .FRAC_BITS   (FRAC_BITS),
      .MAX_OCTAVES (MAX_OCTAVES)
   ) u_lock (
      .clock         (clock),
      .reset         (reset),
      .margin        (margin),
      .mid_ctl       (mid_ctl),
      .mid_pitch     (mid_pitch),
      .mid_center    (mid_center),
      .mid_ready     (mid_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_semitone  (rsp_semitone),
      .rsp_octave    (rsp_octave),
      .rsp_band      (rsp_band),
      .rsp_deviation (rsp_deviation)
   );

endmodule
